FILE: sv/dtfa_pkg.sv
// ----------------------------------------------------------------------------
// dtfa_pkg
// Shared constants, types and helpers for the decimal text to 22.10 adder.
// ----------------------------------------------------------------------------
package dtfa_pkg;

  // Fixed point format
  localparam int FRAC_BITS   = 10;                  // fraction bits of a value
  localparam int VALUE_W     = 32;                  // width of a stored value
  localparam int INT_W       = VALUE_W - FRAC_BITS; // integer accumulator width
  localparam int INT_LIMIT   = 1 << (INT_W - 1);    // first saturating integer
  localparam int INT_PROD_W  = INT_W + 4;           // accum * 10 + digit

  // Token limits
  localparam int MAX_TOKEN   = 15;
  localparam int TOK_W       = $clog2(MAX_TOKEN + 1);
  localparam int FRAC_DIGITS = 5;
  localparam int FRAC_ACC_W  = 17;                  // holds 10^FRAC_DIGITS
  localparam int FRAC_PROD_W = FRAC_ACC_W + 4;
  localparam int DIG_W       = 3;

  // Division sequencer: one quotient bit per cycle
  localparam int DIV_CNT_W   = $clog2(FRAC_BITS + 1);

  // Job queue between parser and finisher (depth must be a power of two)
  localparam int JOBQ_DEPTH  = 2;
  localparam int JOBQ_PTR_W  = $clog2(JOBQ_DEPTH);
  localparam int JOBQ_CNT_W  = $clog2(JOBQ_DEPTH + 1);

  localparam logic [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  // Character codes
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  // One finished token, handed from the parser to the finisher
  typedef struct packed {
    logic                  slot;
    logic                  negative;
    logic                  tok_nz;
    logic                  int_sat;
    logic [INT_W-1:0]      int_acc;
    logic [FRAC_ACC_W-1:0] frac_acc;
    logic [DIG_W-1:0]      frac_digits;
  } job_t;

  // 10^digits, six and up clamp to 10^5
  function automatic logic [FRAC_ACC_W-1:0] pow10(input logic [DIG_W-1:0] digits);
    logic [FRAC_ACC_W-1:0] p;
    case (digits)
      3'd0:    p = FRAC_ACC_W'(1);
      3'd1:    p = FRAC_ACC_W'(10);
      3'd2:    p = FRAC_ACC_W'(100);
      3'd3:    p = FRAC_ACC_W'(1000);
      3'd4:    p = FRAC_ACC_W'(10000);
      default: p = FRAC_ACC_W'(100000);
    endcase
    return p;
  endfunction

endpackage

FILE: sv/dtfa_front.sv
// ----------------------------------------------------------------------------
// dtfa_front
// Character parser: one character per cycle while char_valid_i is set, hands a job out on the last one.
// ----------------------------------------------------------------------------
module dtfa_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          char_valid_i,
  input  logic [7:0]    char_code_i,
  input  logic          slot_i,
  input  logic          last_char_i,
  output logic          job_push_o,
  output dtfa_pkg::job_t job_o
);
  import dtfa_pkg::*;

  typedef enum logic [2:0] {PhWs, PhStart, PhInt, PhFrac, PhDone} phase_e;

  phase_e                phase_q, phase_d, eff;
  logic                  neg_q, neg_d;
  logic [INT_W-1:0]      int_q, int_d;
  logic [FRAC_ACC_W-1:0] frac_q, frac_d;
  logic [DIG_W-1:0]      dig_q, dig_d;
  logic [TOK_W-1:0]      tok_q, tok_d;
  logic                  sat_q, sat_d;
  logic                  go, is_white, is_digit;
  logic [INT_PROD_W-1:0] int_ext, int_prod;
  logic [FRAC_PROD_W-1:0] frac_ext, frac_prod;

  assign is_white  = char_code_i inside {CharSpace, [CharTab:CharCr]};
  assign is_digit  = char_code_i inside {[CharZero:CharNine]};
  assign int_ext   = INT_PROD_W'(int_q);
  assign int_prod  = (int_ext << 3) + (int_ext << 1) + INT_PROD_W'(char_code_i[3:0]);
  assign frac_ext  = FRAC_PROD_W'(frac_q);
  assign frac_prod = (frac_ext << 3) + (frac_ext << 1) + FRAC_PROD_W'(char_code_i[3:0]);

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    int_d   = int_q;
    frac_d  = frac_q;
    dig_d   = dig_q;
    tok_d   = tok_q;
    sat_d   = sat_q;
    go      = 1'b0;
    eff     = phase_q;
    if (phase_q == PhWs) begin
      if (is_white) begin
        go = 1'b0;
      end else if (char_code_i == CharNul) begin
        phase_d = PhDone;
      end else begin
        go  = 1'b1;
        eff = PhStart;
      end
    end else if (tok_q != '0) begin
      go = 1'b1;
    end
    if (go) begin
      if (char_code_i == CharNul || is_white || tok_q >= TOK_W'(MAX_TOKEN)) begin
        phase_d = PhDone;
      end else begin
        tok_d = tok_q + TOK_W'(1);
        if (eff == PhStart && char_code_i == CharMinus) begin
          neg_d   = 1'b1;
          phase_d = PhInt;
        end else if (eff == PhStart && char_code_i == CharPlus) begin
          phase_d = PhInt;
        end else if (eff == PhStart || eff == PhInt) begin
          phase_d = PhInt;
          if (is_digit) begin
            if (int_prod >= INT_PROD_W'(INT_LIMIT)) begin
              int_d = INT_W'(INT_LIMIT);
              sat_d = 1'b1;
            end else begin
              int_d = int_prod[INT_W-1:0];
            end
          end else if (char_code_i == CharDot) begin
            phase_d = PhFrac;
          end else begin
            phase_d = PhDone;
          end
        end else if (eff == PhFrac) begin
          if (is_digit && dig_q < DIG_W'(FRAC_DIGITS)) begin
            frac_d = frac_prod[FRAC_ACC_W-1:0];
            dig_d  = dig_q + DIG_W'(1);
            if (dig_q == DIG_W'(FRAC_DIGITS - 1)) phase_d = PhDone;
          end else begin
            phase_d = PhDone;
          end
        end
      end
    end
  end

  always_comb begin
    job_o.slot        = slot_i;
    job_o.negative    = neg_d;
    job_o.tok_nz      = (tok_d != '0);
    job_o.int_sat     = sat_d;
    job_o.int_acc     = int_d;
    job_o.frac_acc    = frac_d;
    job_o.frac_digits = dig_d;
  end

  assign job_push_o = char_valid_i & last_char_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhWs;
      neg_q   <= 1'b0;
      int_q   <= '0;
      frac_q  <= '0;
      dig_q   <= '0;
      tok_q   <= '0;
      sat_q   <= 1'b0;
    end else if (char_valid_i) begin
      if (last_char_i) begin
        phase_q <= PhWs;
        neg_q   <= 1'b0;
        int_q   <= '0;
        frac_q  <= '0;
        dig_q   <= '0;
        tok_q   <= '0;
        sat_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        int_q   <= int_d;
        frac_q  <= frac_d;
        dig_q   <= dig_d;
        tok_q   <= tok_d;
        sat_q   <= sat_d;
      end
    end
  end

  a_tok_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_q <= TOK_W'(MAX_TOKEN))
    else $error("token length past limit");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_valid_i && last_char_i |=> phase_q == PhWs && tok_q == '0 && !sat_q)
    else $error("parse state not cleared after last beat");

endmodule

FILE: sv/dtfa_jobq.sv
// ----------------------------------------------------------------------------
// dtfa_jobq
// Short job queue between the parser and the finisher.
// ----------------------------------------------------------------------------
module dtfa_jobq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dtfa_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output dtfa_pkg::job_t data_o,
  output logic           empty_o
);
  import dtfa_pkg::*;

  job_t                  ent_q [JOBQ_DEPTH];
  logic [JOBQ_PTR_W-1:0] wr_q, rd_q;
  logic [JOBQ_CNT_W-1:0] cnt_q;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == JOBQ_CNT_W'(JOBQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = ent_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + JOBQ_PTR_W'(1);
      if (do_pop)  rd_q <= rd_q + JOBQ_PTR_W'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + JOBQ_CNT_W'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - JOBQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) ent_q[wr_q] <= data_i;
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job pushed into full queue");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= JOBQ_CNT_W'(JOBQ_DEPTH))
    else $error("job queue count out of range");

endmodule

FILE: sv/dtfa_back.sv
// ----------------------------------------------------------------------------
// dtfa_back
// Finisher: fraction division, value build, operand store and saturated sum.
// ----------------------------------------------------------------------------
module dtfa_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dtfa_pkg::job_t       job_i,
  input  logic                 job_empty_i,
  output logic                 job_pop_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output logic [dtfa_pkg::VALUE_W-1:0] parsed_o,
  output logic [dtfa_pkg::VALUE_W-1:0] sum_o,
  output logic                 ovf_o
);
  import dtfa_pkg::*;

  typedef enum logic [2:0] {SIdle, SDiv, SVal, SStore, SSum} state_e;

  state_e                state_q;
  job_t                  job_q;
  logic [FRAC_ACC_W-1:0] rem_q, div_q;
  logic [FRAC_BITS-1:0]  quo_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic [VALUE_W-1:0]    val_q;
  logic                  ovf_q;
  logic [VALUE_W-1:0]    store_q [2];
  logic                  out_valid_q;
  logic [VALUE_W-1:0]    out_parsed_q, out_sum_q;
  logic                  out_ovf_q;

  logic [FRAC_ACC_W:0]   rem_sh, rem_sub;
  logic                  ge;
  logic [VALUE_W-1:0]    mag;
  logic [VALUE_W:0]      sum;
  logic                  sum_ovf;
  logic                  out_free;
  logic                  out_load;

  // restoring division, one quotient bit per cycle
  assign rem_sh  = {rem_q, 1'b0};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign ge      = (rem_sh >= {1'b0, div_q});

  // integer is below 2^(INT_W-1) here and the quotient below 2^FRAC_BITS
  assign mag     = {job_q.int_acc, quo_q};

  assign sum     = {store_q[0][VALUE_W-1], store_q[0]} + {store_q[1][VALUE_W-1], store_q[1]};
  assign sum_ovf = sum[VALUE_W] ^ sum[VALUE_W-1];

  assign out_free  = ~out_valid_q | pop_i;
  assign out_load  = (state_q == SSum) & out_free;
  assign job_pop_o = (state_q == SIdle) & ~job_empty_i;

  assign empty_o  = ~out_valid_q;
  assign parsed_o = out_parsed_q;
  assign sum_o    = out_sum_q;
  assign ovf_o    = out_ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      job_q        <= '0;
      rem_q        <= '0;
      div_q        <= '0;
      quo_q        <= '0;
      cnt_q        <= '0;
      val_q        <= '0;
      ovf_q        <= 1'b0;
      store_q[0]   <= '0;
      store_q[1]   <= '0;
      out_valid_q  <= 1'b0;
      out_parsed_q <= '0;
      out_sum_q    <= '0;
      out_ovf_q    <= 1'b0;
    end else begin
      if (out_load)   out_valid_q <= 1'b1;
      else if (pop_i) out_valid_q <= 1'b0;
      case (state_q)
        SIdle: begin
          if (!job_empty_i) begin
            job_q   <= job_i;
            rem_q   <= job_i.frac_acc;
            div_q   <= pow10(job_i.frac_digits);
            quo_q   <= '0;
            cnt_q   <= '0;
            state_q <= SDiv;
          end
        end
        SDiv: begin
          rem_q <= ge ? rem_sub[FRAC_ACC_W-1:0] : rem_sh[FRAC_ACC_W-1:0];
          quo_q <= {quo_q[FRAC_BITS-2:0], ge};
          cnt_q <= cnt_q + DIV_CNT_W'(1);
          if (cnt_q == DIV_CNT_W'(FRAC_BITS - 1)) state_q <= SVal;
        end
        SVal: begin
          if (job_q.int_sat) val_q <= job_q.negative ? VAL_MIN : VAL_MAX;
          else               val_q <= job_q.negative ? (VALUE_W'(0) - mag) : mag;
          ovf_q   <= job_q.tok_nz & job_q.int_sat;
          state_q <= SStore;
        end
        SStore: begin
          // an empty token leaves the slot as it was
          if (job_q.tok_nz) store_q[job_q.slot] <= val_q;
          state_q <= SSum;
        end
        SSum: begin
          if (out_free) begin
            out_parsed_q <= store_q[job_q.slot];
            out_sum_q    <= sum_ovf ? (sum[VALUE_W] ? VAL_MIN : VAL_MAX) : sum[VALUE_W-1:0];
            out_ovf_q    <= ovf_q | sum_ovf;
            state_q      <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SDiv |-> rem_q < div_q)
    else $error("division remainder not below divisor");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SSum && out_free |=> out_valid_q && state_q == SIdle)
    else $error("result not loaded into output register");

endmodule

FILE: sv/decimal_text_to_fixed_point_adder_top.sv
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point_adder_top
// Parses decimal text into signed 22.10 operands and returns value and sum.
//
// Channel   Dir  Handshake            Beat payload
// --------  ---  -------------------  ------------------------------------------
// text in   in   push / full          char_code_i, slot_i, last_char_i
// result    out  empty / pop          parsed_value_o, sum_value_o, overflow_o
//
// Flow: the parser takes a character beat whenever the job queue has room. A beat
// marked last hands a job to a two-entry queue; the finisher works one job at a
// time through division, value build, store and sum, and pops the next only in
// idle; its fraction divider yields one bit per cycle.
// Stalls: full rises only when both job slots are occupied; the finisher
// waits in its sum step while an unpopped result sits in the output register.
// Reset: asynchronous, active low; operands reset to zero, no clearing pass.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_point_adder_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         char_code_i,
  input  logic               slot_i,
  input  logic               last_char_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] parsed_value_o,
  output logic signed [31:0] sum_value_o,
  output logic               overflow_o
);
  import dtfa_pkg::*;

  logic               in_acc;
  logic               job_push, job_pop, jobq_empty, jobq_full;
  job_t               job_in, job_out;
  logic [VALUE_W-1:0] parsed, sum;

  // a text beat is taken whenever the job queue has room
  assign full   = jobq_full;
  assign in_acc = push & ~jobq_full;

  dtfa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_valid_i (in_acc),
    .char_code_i  (char_code_i),
    .slot_i       (slot_i),
    .last_char_i  (last_char_i),
    .job_push_o   (job_push),
    .job_o        (job_in)
  );

  dtfa_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (jobq_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (jobq_empty)
  );

  // finisher owns the operand store and the output register
  dtfa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .job_empty_i (jobq_empty),
    .job_pop_o   (job_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .parsed_o    (parsed),
    .sum_o       (sum),
    .ovf_o       (overflow_o)
  );

  assign parsed_value_o = $signed(parsed);
  assign sum_value_o    = $signed(sum);

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks decimal_text_to_fixed_point_adder_top: character beats go in, each
// text ends in one result beat that is matched against a software parser
// that runs in lockstep with the stimulus.
// ----------------------------------------------------------------------------
module tb;
  import dtfa_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 3;
  localparam int DRAIN_CYCLES = 40;       // quiet stretch to catch stray result beats
  localparam int LIMIT_CYCLES = 400_000;  // far above the slowest legal run

  // Scan phases of one text
  typedef enum logic [2:0] {
    SCAN_LEAD,   // skipping leading whitespace
    SCAN_SIGN,   // first token character, sign allowed
    SCAN_INT,    // integer digits
    SCAN_FRAC,   // fraction digits after the dot
    SCAN_STOP    // token closed, rest of text ignored
  } scan_phase_e;

  // One result beat as the block should present it
  typedef struct packed {
    logic [31:0] value;
    logic [31:0] total;
    logic        ovf;
  } adder_out_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               push;
  logic               full;
  logic [7:0]         char_code;
  logic               slot;
  logic               last_char;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [31:0] parsed_value;
  logic signed [31:0] sum_value;
  logic               overflow;

  // Parser copy, advanced on every accepted character beat
  scan_phase_e scan_ph;
  logic        neg;
  int unsigned int_acc;
  int unsigned frac_acc;
  int unsigned frac_n;
  int unsigned tok_len;
  logic        int_sat;
  logic [31:0] opnd [2];

  adder_out_t  parsed_sums_q [$];
  logic [7:0]  text_buf [$];

  int mismatch_cnt = 0;
  int results_seen = 0;
  int chars_sent   = 0;
  int texts_sent   = 0;
  int sat_results  = 0;
  int cycle_cnt    = 0;
  int stall_left   = 0;
  bit idle_off     = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  decimal_text_to_fixed_point_adder_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .push           (push),
    .full           (full),
    .char_code_i    (char_code),
    .slot_i         (slot),
    .last_char_i    (last_char),
    .empty          (empty),
    .pop            (pop),
    .parsed_value_o (parsed_value),
    .sum_value_o    (sum_value),
    .overflow_o     (overflow)
  );

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------
  function bit is_space(input logic [7:0] c);
    return c == CharSpace || (c >= CharTab && c <= CharCr);
  endfunction

  function bit is_digit(input logic [7:0] c);
    return c >= CharZero && c <= CharNine;
  endfunction

  function void clear_scan();
    scan_ph  = SCAN_LEAD;
    neg      = 1'b0;
    int_acc  = 0;
    frac_acc = 0;
    frac_n   = 0;
    tok_len  = 0;
    int_sat  = 1'b0;
  endfunction

  // Advance the parser by one character
  function void scan_char(input logic [7:0] c);
    if (scan_ph == SCAN_LEAD) begin
      if (is_space(c)) return;
      if (c == CharNul) begin
        scan_ph = SCAN_STOP;
        return;
      end
      scan_ph = SCAN_SIGN;
    end else if (tok_len == 0) begin
      return;  // text ended before any token character
    end
    if (c == CharNul || is_space(c) || tok_len >= MAX_TOKEN) begin
      scan_ph = SCAN_STOP;
      return;
    end
    tok_len++;
    if (scan_ph == SCAN_SIGN && c == CharMinus) begin
      neg     = 1'b1;
      scan_ph = SCAN_INT;
    end else if (scan_ph == SCAN_SIGN && c == CharPlus) begin
      scan_ph = SCAN_INT;
    end else if (scan_ph == SCAN_SIGN || scan_ph == SCAN_INT) begin
      scan_ph = SCAN_INT;
      if (is_digit(c)) begin
        int_acc = int_acc * 10 + (c - CharZero);
        if (int_acc >= INT_LIMIT) begin
          int_acc = INT_LIMIT;
          int_sat = 1'b1;
        end
      end else if (c == CharDot) begin
        scan_ph = SCAN_FRAC;
      end else begin
        scan_ph = SCAN_STOP;
      end
    end else if (scan_ph == SCAN_FRAC) begin
      if (is_digit(c) && frac_n < FRAC_DIGITS) begin
        frac_acc = frac_acc * 10 + (c - CharZero);
        frac_n++;
        if (frac_n >= FRAC_DIGITS) scan_ph = SCAN_STOP;
      end else begin
        scan_ph = SCAN_STOP;
      end
    end
  endfunction

  // Last character: build the 22.10 value, update the slot, queue the beat
  function void close_number(input logic sl);
    adder_out_t       r;
    longint unsigned  scale;
    longint unsigned  frac_part;
    logic [31:0]      mag;
    logic signed [32:0] total;
    int               k;
    r.ovf = 1'b0;
    if (tok_len != 0) begin
      if (int_sat) begin
        opnd[sl] = neg ? VAL_MIN : VAL_MAX;
        r.ovf    = 1'b1;
      end else begin
        scale = 1;
        for (k = 0; k < frac_n; k++) scale = scale * 10;
        frac_part = 64'(frac_acc);
        frac_part = (frac_part << FRAC_BITS) / scale;
        mag       = (int_acc << FRAC_BITS) + frac_part[31:0];
        opnd[sl]  = neg ? -mag : mag;
      end
    end
    total = $signed({opnd[0][31], opnd[0]}) + $signed({opnd[1][31], opnd[1]});
    if (total[32] != total[31]) begin
      r.total = total[32] ? VAL_MIN : VAL_MAX;
      r.ovf   = 1'b1;
    end else begin
      r.total = total[31:0];
    end
    r.value = opnd[sl];
    if (r.ovf) sat_results++;
    parsed_sums_q.push_back(r);
    clear_scan();
  endfunction

  // --------------------------------------------------------------------------
  // Idle gaps: mostly none or short, a few long
  // --------------------------------------------------------------------------
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (idle_off || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Character beat sender
  // --------------------------------------------------------------------------
  task send_char(input logic [7:0] c, input logic sl, input logic last);
    int gap;
    push      <= 1'b1;
    char_code <= c;
    slot      <= sl;
    last_char <= last;
    do @(posedge clk); while (full);
    // beat taken at this edge
    scan_char(c);
    if (last) close_number(sl);
    chars_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      push      <= 1'b0;
      char_code <= 8'($urandom);
      slot      <= 1'($urandom_range(0, 1));
      last_char <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
  endtask

  // Send text_buf; slot only matters on the last beat, so it is noise before
  task send_buf(input logic sl);
    int i;
    for (i = 0; i < text_buf.size(); i++) begin
      if (i == text_buf.size() - 1) send_char(text_buf[i], sl, 1'b1);
      else send_char(text_buf[i], 1'($urandom_range(0, 1)), 1'b0);
    end
    texts_sent++;
  endtask

  function void add_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  task send_str(input string s, input logic sl);
    text_buf.delete();
    add_str(s);
    send_buf(sl);
  endtask

  // --------------------------------------------------------------------------
  // Random text builders
  // --------------------------------------------------------------------------
  function logic [7:0] ws_char();
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) return CharSpace;
    return 8'(CharTab + r - 1);
  endfunction

  function logic [7:0] digit_char();
    return 8'(CharZero + $urandom_range(0, 9));
  endfunction

  function logic [7:0] rand_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return digit_char();
    if (r == 4) return $urandom_range(0, 1) ? CharPlus : CharMinus;
    if (r == 5) return CharDot;
    if (r == 6) return ws_char();
    if (r == 7) return CharNul;
    return 8'($urandom_range(0, 255));
  endfunction

  // Well-formed number with random content and an optional tail
  function void build_number();
    int r;
    int n;
    text_buf.delete();
    repeat ($urandom_range(0, 2)) text_buf.push_back(ws_char());
    r = $urandom_range(0, 2);
    if (r == 1) text_buf.push_back(CharPlus);
    if (r == 2) text_buf.push_back(CharMinus);
    r = $urandom_range(0, 19);
    if (r == 0) begin
      add_str($sformatf("%0d", INT_LIMIT - 2 + $urandom_range(0, 3)));  // around saturation
    end else if (r == 1) begin
      repeat ($urandom_range(8, 16)) text_buf.push_back(CharZero);      // long token
    end else begin
      n = (r < 4) ? $urandom_range(5, 9) : $urandom_range(0, 4);
      repeat (n) text_buf.push_back(digit_char());
    end
    if ($urandom_range(0, 9) < 7) begin
      text_buf.push_back(CharDot);
      repeat ($urandom_range(0, 6)) text_buf.push_back(digit_char());
    end
    r = $urandom_range(0, 5);
    if (r == 0) begin
      text_buf.push_back(ws_char());
      text_buf.push_back(rand_char());
    end else if (r == 1) begin
      text_buf.push_back(CharNul);
      text_buf.push_back(rand_char());
    end else if (r == 2) begin
      text_buf.push_back(rand_char());
    end
    if (text_buf.size() == 0) text_buf.push_back(digit_char());
  endfunction

  function void build_noise();
    text_buf.delete();
    repeat ($urandom_range(1, 10)) text_buf.push_back(rand_char());
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task test_plain_numbers();
    send_str("0", 1'b0);
    send_str("123.5", 1'b1);
    send_str("+3.141599", 1'b0);   // sixth fraction digit dropped
    send_str("1.00001", 1'b1);     // fraction truncates to zero
    send_str(".99999", 1'b0);
    send_str("-", 1'b1);           // sign alone
    send_str(".", 1'b0);           // dot alone
    send_str("12a34", 1'b1);       // stops at the letter
    send_str("1.2.3", 1'b0);       // stops at the second dot
    text_buf.delete();
    text_buf.push_back(8'hFF);     // lone non-digit still counts as a token
    send_buf(1'b1);
  endtask

  task test_whitespace_and_nul();
    int c;
    text_buf.delete();
    text_buf.push_back(CharSpace);
    for (c = CharTab; c <= CharCr; c++) text_buf.push_back(8'(c));
    add_str("-7.25");
    send_buf(1'b0);
    send_str("5 6", 1'b1);         // whitespace ends the token
    send_str("   ", 1'b0);         // empty token, slot keeps its value
    text_buf.delete();
    add_str("12");
    text_buf.push_back(CharNul);
    add_str(" 34");
    send_buf(1'b1);                // NUL ends the text
    text_buf.delete();
    text_buf.push_back(CharNul);
    add_str(" 5");
    send_buf(1'b0);                // NUL before any token
  endtask

  task test_token_limits();
    send_str("000000000000012345", 1'b1);  // cut after 15 characters
    send_str("0000000000000.5", 1'b0);     // exactly 15
    send_str("00000000000000.5", 1'b1);    // digit falls past the limit
  endtask

  task test_saturation();
    send_str("2097151.99999", 1'b0);       // largest unsaturated magnitude
    send_str("2097152", 1'b1);             // integer saturates positive
    send_str("-2097152", 1'b0);            // integer saturates negative
    send_str("99999999999", 1'b1);
    send_str("2097151.9", 1'b0);
    send_str("2097151.9", 1'b1);           // sum saturates positive
    send_str("-2097151.9", 1'b0);
    send_str("-2097151.9", 1'b1);          // sum saturates negative
  endtask

  // Mostly well-formed numbers, some noise and broken texts
  task test_random_texts(input int n_chars);
    int start;
    start = chars_sent;
    while (chars_sent - start < n_chars) begin
      if ($urandom_range(0, 4) != 0) build_number();
      else build_noise();
      send_buf(1'($urandom_range(0, 1)));
    end
  endtask

  // No gaps on either side: fills the job queue so full is exercised
  task test_back_to_back(input int n_chars);
    idle_off = 1'b1;
    test_random_texts(n_chars);
    idle_off = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random pop stalls
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_drain
    int g;
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (pop && !empty) begin
      g          = pick_gap();
      stall_left = g;
      pop       <= (g == 0);
    end else if (stall_left != 0) begin
      stall_left--;
      pop <= (stall_left == 0);
    end else begin
      pop <= 1'b1;
    end
  end

  task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("tb: mismatch on %s, got %h want %h (result %0d)", what, got, want,
             results_seen);
    mismatch_cnt++;
  endtask

  // Each popped beat against the oldest queued prediction
  always @(posedge clk) begin : result_check
    adder_out_t want;
    if (rst_n && pop && !empty) begin
      if (parsed_sums_q.size() == 0) begin
        report_mismatch("unexpected result", parsed_value, 32'h0);
      end else begin
        want = parsed_sums_q.pop_front();
        if (parsed_value !== want.value)
          report_mismatch("parsed_value", parsed_value, want.value);
        if (sum_value !== want.total)
          report_mismatch("sum_value", sum_value, want.total);
        if (overflow !== want.ovf)
          report_mismatch("overflow", {31'b0, overflow}, {31'b0, want.ovf});
      end
      results_seen++;
    end
  end

  // Watchdog
  initial begin
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n     = 1'b0;
    push      = 1'b0;
    char_code = 8'h00;
    slot      = 1'b0;
    last_char = 1'b0;
    clear_scan();
    opnd[0] = 32'h0;
    opnd[1] = 32'h0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_plain_numbers();
    test_whitespace_and_nul();
    test_token_limits();
    test_saturation();
    test_random_texts(510);
    test_back_to_back(200);
    push <= 1'b0;

    // all predictions out, then a quiet stretch to catch stray beats
    while (parsed_sums_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d texts in %0d character beats, %0d results checked (%0d saturated)",
             texts_sent, chars_sent, results_seen, sat_results);
    if (mismatch_cnt == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
